// ===== hw/rtl/tfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Texel format converter package
// Shared widths, codes, configuration and stage types, and the bit
// reordering helpers used by the conversion pipeline.
// ----------------------------------------------------------------------------
package tfc_pkg;

   // Default parameter values.
   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int MAX_DIMENSION_DEFAULT = 1024;

   // Fixed field widths.
   localparam int SLOT_W    = 8;
   localparam int COORD_W   = 10;
   localparam int WORD_W    = 32;
   localparam int OFFSET_W  = 22;
   localparam int WIDTH_W   = 11;
   localparam int ENTRIES_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 11;
   localparam int POW2_W    = 12;

   // Source formats.
   typedef enum logic [1:0] {
      FMT_RGBA32   = 2'd0,
      FMT_RGBA4444 = 2'd1,
      FMT_INDEXED4 = 2'd2,
      FMT_INDEXED8 = 2'd3
   } color_format_type;

   // Input commands.
   typedef enum logic {
      CMD_PALETTE_WRITE = 1'b0,
      CMD_CONVERT       = 1'b1
   } command_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLOR_FORMAT    = 2'd0,
      CSR_TEXTURE_WIDTH   = 2'd1,
      CSR_PALETTE_ENTRIES = 2'd2
   } csr_index_type;

   // Configuration seen by the pipeline.
   typedef struct packed {
      color_format_type       color_format;
      logic [WIDTH_W-1:0]     texture_width;
      logic [ENTRIES_W-1:0]   palette_entries;
   } cfg_type;

   // Front stage contents handed to the result stage.
   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [WORD_W-1:0]   direct_texel;
      logic                wide_texel;
      logic                use_palette;
      logic                palette_error;
   } stage_type;

   // Reverse the four bytes of a word.
   function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // RGBA4444 little-endian halfword into native ABGR nibble order.
   function automatic logic [15:0] native_rgba4(input logic [15:0] half);
      return {half[3:0], half[7:4], half[11:8], half[15:12]};
   endfunction

   // Smallest power of two not below w; 1 for a width of zero or one.
   function automatic logic [POW2_W-1:0] ceil_pow2(input logic [WIDTH_W-1:0] w);
      logic [WIDTH_W-1:0] m;
      logic [3:0]         pos;
      logic [POW2_W-1:0]  p;
      m   = w - WIDTH_W'(1);
      pos = '0;
      for (int i = 0; i < WIDTH_W; i++) begin
         if (m[i]) begin
            pos = 4'(i);
         end
      end
      if (w <= WIDTH_W'(1)) begin
         p = POW2_W'(1);
      end else begin
         p = POW2_W'(1) << (pos + 4'd1);
      end
      return p;
   endfunction

endpackage

// ===== hw/rtl/tfc_ifs.sv =====
// ----------------------------------------------------------------------------
// Texel format converter channels
// Valid/ready interfaces for the request, response and register channels.
// ----------------------------------------------------------------------------
interface tfc_req_if import tfc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                command;
   logic [SLOT_W-1:0]   palette_slot;
   logic [COORD_W-1:0]  column;
   logic [COORD_W-1:0]  row;
   logic [WORD_W-1:0]   source_word;

   modport source (output valid, command, palette_slot, column, row, source_word,
                   input ready);
   modport sink   (input valid, command, palette_slot, column, row, source_word,
                   output ready);
endinterface

interface tfc_rsp_if import tfc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] byte_offset;
   logic [WORD_W-1:0]   texel_word;
   logic                wide_texel;
   logic                palette_error;

   modport source (output valid, byte_offset, texel_word, wide_texel, palette_error,
                   input ready);
   modport sink   (input valid, byte_offset, texel_word, wide_texel, palette_error,
                   output ready);
endinterface

interface tfc_csr_if import tfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tfc_csr.sv =====
// ----------------------------------------------------------------------------
// Texel format converter registers
// Holds the configuration registers and the padded row pitch derived
// from the texture width when it is written.
// ----------------------------------------------------------------------------
module tfc_csr import tfc_pkg::*; #(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT,
   localparam int PAD_W = $clog2(MAX_DIMENSION + 1)
) (
   input  logic            clock,
   input  logic            reset,
   tfc_csr_if.sink         csr_bus,
   output cfg_type         cfg,
   output logic [PAD_W-1:0] padded_width
);

   localparam int CMP_W = (PAD_W > POW2_W) ? PAD_W : POW2_W;

   cfg_type            cfg_ff, cfg_in;
   logic [PAD_W-1:0]   pad_ff, pad_in;
   logic [POW2_W-1:0]  pow2;
   logic               wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;
   assign pow2          = ceil_pow2(csr_bus.data);

   // Register update on a write transaction.
   always_comb begin
      cfg_in = cfg_ff;
      pad_in = pad_ff;
      if (wr_en) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_COLOR_FORMAT: begin
               cfg_in.color_format = color_format_type'(csr_bus.data[1:0]);
            end
            CSR_TEXTURE_WIDTH: begin
               cfg_in.texture_width = csr_bus.data;
               if (CMP_W'(pow2) > CMP_W'(MAX_DIMENSION)) begin
                  pad_in = PAD_W'(MAX_DIMENSION);
               end else begin
                  pad_in = PAD_W'(pow2);
               end
            end
            CSR_PALETTE_ENTRIES: begin
               cfg_in.palette_entries = csr_bus.data[ENTRIES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_format    <= FMT_RGBA32;
         cfg_ff.texture_width   <= WIDTH_W'(1);
         cfg_ff.palette_entries <= ENTRIES_W'(1);
         pad_ff                 <= PAD_W'(1);
      end else begin
         cfg_ff <= cfg_in;
         pad_ff <= pad_in;
      end
   end

   assign cfg          = cfg_ff;
   assign padded_width = pad_ff;

endmodule

// ===== hw/rtl/tfc_front.sv =====
// ----------------------------------------------------------------------------
// Texel format converter front stage
// Takes request transactions, writes and reads the palette store, and
// registers the staging offset and the direct conversions.
// ----------------------------------------------------------------------------
module tfc_front import tfc_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT,
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT,
   localparam int PAD_W = $clog2(MAX_DIMENSION + 1)
) (
   input  logic             clock,
   input  logic             reset,
   tfc_req_if.sink          req_bus,
   input  cfg_type          cfg,
   input  logic [PAD_W-1:0] padded_width,
   input  logic             take,
   output logic             stage_valid,
   output stage_type        stage,
   output logic [WORD_W-1:0] palette_word
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int SUM_W  = COORD_W + PAD_W + 1;
   localparam int WIDE_W = SUM_W + 2 + OFFSET_W;

   logic [WORD_W-1:0]   palette_mem [PALETTE_DEPTH];
   logic [WORD_W-1:0]   pal_rd_ff;
   logic                valid_ff, valid_in;
   stage_type           stage_ff, stage_in;
   logic                accept, convert, pal_write;
   logic [SLOT_W-1:0]   index;
   logic                odd_pixel;
   logic [SUM_W-1:0]    pitch_sum;
   logic [WIDE_W-1:0]   offset_wide;
   logic                indexed;

   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;
   assign convert       = accept && (command_type'(req_bus.command) == CMD_CONVERT);
   assign pal_write     = accept && (command_type'(req_bus.command) == CMD_PALETTE_WRITE)
                          && ({1'b0, req_bus.palette_slot} < ENTRIES_W'(PALETTE_DEPTH));

   // Pixel parity of row * width + column only needs the low bits.
   assign odd_pixel = (req_bus.row[0] & cfg.texture_width[0]) ^ req_bus.column[0];

   // Palette index for the indexed formats.
   always_comb begin
      if (cfg.color_format == FMT_INDEXED4) begin
         index = odd_pixel ? {4'd0, req_bus.source_word[7:4]}
                           : {4'd0, req_bus.source_word[3:0]};
      end else begin
         index = req_bus.source_word[7:0];
      end
   end

   // Staging offset: row pitch times row plus column, scaled by texel size.
   assign pitch_sum = SUM_W'(req_bus.row) * SUM_W'(padded_width) + SUM_W'(req_bus.column);
   assign offset_wide = (cfg.color_format == FMT_RGBA4444) ? (WIDE_W'(pitch_sum) << 1)
                                                           : (WIDE_W'(pitch_sum) << 2);
   assign indexed = (cfg.color_format == FMT_INDEXED4) ||
                    (cfg.color_format == FMT_INDEXED8);

   // Next stage contents.
   always_comb begin
      stage_in             = stage_ff;
      stage_in.byte_offset = offset_wide[OFFSET_W-1:0];
      stage_in.use_palette = indexed;
      stage_in.wide_texel  = (cfg.color_format != FMT_RGBA4444);
      stage_in.palette_error = indexed &&
         (({1'b0, index} >= cfg.palette_entries) ||
          ({1'b0, index} >= ENTRIES_W'(PALETTE_DEPTH)));
      if (cfg.color_format == FMT_RGBA4444) begin
         stage_in.direct_texel = {16'd0, native_rgba4(req_bus.source_word[15:0])};
      end else begin
         stage_in.direct_texel = swap_bytes(req_bus.source_word);
      end
   end

   // Stage occupancy.
   always_comb begin
      if (convert) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (convert) begin
         stage_ff <= stage_in;
      end
   end

   // Palette store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (pal_write) begin
         palette_mem[req_bus.palette_slot[PAL_AW-1:0]] <= req_bus.source_word;
      end
   end

   always_ff @(posedge clock) begin
      if (convert) begin
         pal_rd_ff <= palette_mem[index[PAL_AW-1:0]];
      end
   end

   assign stage_valid  = valid_ff;
   assign stage        = stage_ff;
   assign palette_word = pal_rd_ff;

endmodule

// ===== hw/rtl/tfc_back.sv =====
// ----------------------------------------------------------------------------
// Texel format converter result stage
// Selects the final texel word and holds the response until it is taken.
// ----------------------------------------------------------------------------
module tfc_back import tfc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              stage_valid,
   input  stage_type         stage,
   input  logic [WORD_W-1:0] palette_word,
   output logic              take,
   tfc_rsp_if.source         rsp_bus
);

   logic                valid_ff, valid_in;
   logic [OFFSET_W-1:0] offset_ff;
   logic [WORD_W-1:0]   texel_ff, texel_in;
   logic                wide_ff;
   logic                error_ff;

   assign take = stage_valid && (!valid_ff || rsp_bus.ready);

   // Indexed texels come from the palette, byte-reversed, or zero on error.
   always_comb begin
      if (!stage.use_palette) begin
         texel_in = stage.direct_texel;
      end else if (stage.palette_error) begin
         texel_in = '0;
      end else begin
         texel_in = swap_bytes(palette_word);
      end
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         offset_ff <= stage.byte_offset;
         texel_ff  <= texel_in;
         wide_ff   <= stage.wide_texel;
         error_ff  <= stage.palette_error;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.byte_offset   = offset_ff;
   assign rsp_bus.texel_word    = texel_ff;
   assign rsp_bus.wide_texel    = wide_ff;
   assign rsp_bus.palette_error = error_ff;

endmodule

// ===== hw/rtl/texel_format_converter.sv =====
// A convert passes the front register and then the result register before its response.
// Throughput: one transaction per cycle while the response channel is ready.
// Palette writes give no response.
// Reset clears the CSRs and pipeline valids; the palette store is not cleared.
// ----------------------------------------------------------------------------
// Texel format converter
// Converts texels into the staging layout and computes their byte offsets.
// ----------------------------------------------------------------------------
module texel_format_converter import tfc_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEFAULT,
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tfc_req_if.sink   req_bus,
   tfc_rsp_if.source rsp_bus,
   tfc_csr_if.sink   csr_bus
);

   localparam int PAD_W = $clog2(MAX_DIMENSION + 1);

   cfg_type           cfg;
   logic [PAD_W-1:0]  padded_width;
   logic              take;
   logic              stage_valid;
   stage_type         stage;
   logic [WORD_W-1:0] palette_word;

   // Configuration registers.
   tfc_csr #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_bus      (csr_bus),
      .cfg          (cfg),
      .padded_width (padded_width)
   );

   // Front stage with the palette store.
   tfc_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .cfg          (cfg),
      .padded_width (padded_width),
      .take         (take),
      .stage_valid  (stage_valid),
      .stage        (stage),
      .palette_word (palette_word)
   );

   // Result register.
   tfc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .stage_valid  (stage_valid),
      .stage        (stage),
      .palette_word (palette_word),
      .take         (take),
      .rsp_bus      (rsp_bus)
   );

endmodule

// ===== test/texel_format_converter_test.sv =====
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// Texel format converter testbench
// Drives palette writes and texel conversions through the request channel
// under random idle gaps and response stalls. A scoreboard predicts the
// staging offset and converted word of every accepted conversion and
// checks each response, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module texel_format_converter_test import tfc_pkg::*; ();

   localparam int PAL_DEPTH     = PALETTE_DEPTH_DEFAULT;
   localparam int MAX_DIM       = MAX_DIMENSION_DEFAULT;
   localparam int RANDOM_ITEMS  = 1300;
   localparam int LIMIT_CYCLES  = 500000;
   localparam int SETTLE_CYCLES = 4;

   // One request transaction and one response transaction.
   typedef struct packed {
      command_type          command;
      logic [SLOT_W-1:0]    palette_slot;
      logic [COORD_W-1:0]   column;
      logic [COORD_W-1:0]   row;
      logic [WORD_W-1:0]    source_word;
   } texel_request_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]  byte_offset;
      logic [WORD_W-1:0]    texel_word;
      logic                 wide_texel;
      logic                 palette_error;
   } texel_result_type;

   // Scoreboard: keeps its own registers and palette, predicts each
   // conversion and compares responses in order.
   class texel_scoreboard;
      color_format_type     fmt;
      logic [WIDTH_W-1:0]   width;
      logic [ENTRIES_W-1:0] entries;
      logic [WORD_W-1:0]    palette_copy [PAL_DEPTH];
      texel_result_type     expected_texels [$];
      int unsigned          failures;

      function new();
         fmt      = FMT_RGBA32;
         width    = WIDTH_W'(1);
         entries  = ENTRIES_W'(1);
         failures = 0;
      endfunction

      // True when a conversion reads the palette; slot gives the entry.
      static function bit reads_palette(input color_format_type f,
                                        input logic [WIDTH_W-1:0] w,
                                        input logic [ENTRIES_W-1:0] n,
                                        input logic [COORD_W-1:0] col,
                                        input logic [COORD_W-1:0] row,
                                        input logic [WORD_W-1:0] word,
                                        output logic [SLOT_W-1:0] slot);
         int unsigned limit;
         logic [8:0]  idx;
         limit = (n > PAL_DEPTH) ? PAL_DEPTH : n;
         // Odd pixel index takes the high nibble; only bit 0 of row*width+col matters.
         if (f == FMT_INDEXED4) begin
            idx = ((row[0] & w[0]) ^ col[0]) ? 9'(word[7:4]) : 9'(word[3:0]);
         end else begin
            idx = 9'(word[7:0]);
         end
         slot = idx[7:0];
         return (f == FMT_INDEXED4 || f == FMT_INDEXED8) && (idx < limit);
      endfunction

      static function logic [WORD_W-1:0] reverse_bytes(input logic [WORD_W-1:0] v);
         return {v[7:0], v[15:8], v[23:16], v[31:24]};
      endfunction

      // Row pitch in texels: next power of two, saturating at the maximum.
      static function int unsigned row_pitch(input logic [WIDTH_W-1:0] w);
         int unsigned p;
         p = 1;
         while (p < w && p < MAX_DIM) begin
            p = p << 1;
         end
         return p;
      endfunction

      function void set_register(input csr_index_type idx, input logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_COLOR_FORMAT:    fmt     = color_format_type'(data[1:0]);
            CSR_TEXTURE_WIDTH:   width   = data[WIDTH_W-1:0];
            CSR_PALETTE_ENTRIES: entries = data[ENTRIES_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_texels.size();
      endfunction

      // Note an accepted request: palette writes update the copy, conversions
      // queue their predicted response.
      function void note_request(input texel_request_type item);
         texel_result_type   texel;
         logic [SLOT_W-1:0]  slot;
         bit                 hit;
         int unsigned        texel_bytes;
         logic [15:0]        half;
         if (item.command == CMD_PALETTE_WRITE) begin
            palette_copy[item.palette_slot] = item.source_word;
            return;
         end
         texel_bytes = (fmt == FMT_RGBA4444) ? 2 : 4;
         texel.byte_offset = OFFSET_W'((item.row * row_pitch(width) + item.column)
                                       * texel_bytes);
         texel.texel_word    = '0;
         texel.wide_texel    = 1'b1;
         texel.palette_error = 1'b0;
         case (fmt)
            FMT_RGBA32: begin
               texel.texel_word = reverse_bytes(item.source_word);
            end
            FMT_RGBA4444: begin
               half = item.source_word[15:0];
               texel.texel_word = {16'h0000, half[3:0], half[7:4], half[11:8], half[15:12]};
               texel.wide_texel = 1'b0;
            end
            default: begin
               hit = reads_palette(fmt, width, entries, item.column, item.row,
                                   item.source_word, slot);
               if (hit) begin
                  texel.texel_word = reverse_bytes(palette_copy[slot]);
               end else begin
                  texel.palette_error = 1'b1;
               end
            end
         endcase
         expected_texels.push_back(texel);
      endfunction

      task report_mismatch(input string what, input logic [WORD_W-1:0] got,
                           input logic [WORD_W-1:0] want);
         failures++;
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_response(input texel_result_type got);
         texel_result_type want;
         if (expected_texels.size() == 0) begin
            report_mismatch("response with no texel pending", WORD_W'(got.byte_offset), '0);
            return;
         end
         want = expected_texels.pop_front();
         if (got.byte_offset !== want.byte_offset) begin
            report_mismatch("byte_offset", WORD_W'(got.byte_offset), WORD_W'(want.byte_offset));
         end
         if (got.texel_word !== want.texel_word) begin
            report_mismatch("texel_word", got.texel_word, want.texel_word);
         end
         if (got.wide_texel !== want.wide_texel) begin
            report_mismatch("wide_texel", WORD_W'(got.wide_texel), WORD_W'(want.wide_texel));
         end
         if (got.palette_error !== want.palette_error) begin
            report_mismatch("palette_error", WORD_W'(got.palette_error),
                            WORD_W'(want.palette_error));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   tfc_req_if req_bus();
   tfc_rsp_if rsp_bus();
   tfc_csr_if csr_bus();

   texel_format_converter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   texel_scoreboard      scoreboard = new();

   // Settings as last programmed, used to shape the stimulus.
   color_format_type     cur_fmt;
   logic [WIDTH_W-1:0]   cur_width;
   logic [ENTRIES_W-1:0] cur_entries;
   bit [PAL_DEPTH-1:0]   slot_written;
   int                   burst_left;
   int unsigned          cycle_count;

   // Clock.
   initial begin
      clock = 1'b0;
      forever begin
         #5 clock = ~clock;
      end
   end

   // Watchdog: ends a run that hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Observe every accepted transaction on the three channels.
   always @(posedge clock) begin
      texel_request_type item;
      texel_result_type  result;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            scoreboard.set_register(csr_index_type'(csr_bus.index), csr_bus.data);
         end
         if (req_bus.valid && req_bus.ready) begin
            item.command      = command_type'(req_bus.command);
            item.palette_slot = req_bus.palette_slot;
            item.column       = req_bus.column;
            item.row          = req_bus.row;
            item.source_word  = req_bus.source_word;
            scoreboard.note_request(item);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result.byte_offset   = rsp_bus.byte_offset;
            result.texel_word    = rsp_bus.texel_word;
            result.wide_texel    = rsp_bus.wide_texel;
            result.palette_error = rsp_bus.palette_error;
            scoreboard.check_response(result);
         end
      end
   end

   // Response backpressure: runs of ready mixed with stalls, mostly short.
   initial begin
      int r;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(60, 120)) @(posedge clock);
            end else begin
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end
         end else begin
            rsp_bus.ready <= 1'b0;
            r = $urandom_range(0, 99);
            if (r < 70) begin
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else if (r < 95) begin
               repeat ($urandom_range(4, 8)) @(posedge clock);
            end else begin
               repeat ($urandom_range(15, 40)) @(posedge clock);
            end
         end
      end
   end

   // Gap before the next request: often none, sometimes long, with bursts.
   function automatic int idle_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic push_request(input texel_request_type item);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= item.command;
      req_bus.palette_slot <= item.palette_slot;
      req_bus.column       <= item.column;
      req_bus.row          <= item.row;
      req_bus.source_word  <= item.source_word;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_palette(input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] color);
      texel_request_type item;
      item.command      = CMD_PALETTE_WRITE;
      item.palette_slot = slot;
      item.column       = COORD_W'($urandom());
      item.row          = COORD_W'($urandom());
      item.source_word  = color;
      slot_written[slot] = 1'b1;
      push_request(item);
   endtask

   // A conversion that would read a palette entry never written gets that
   // entry filled first.
   task automatic send_convert(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                               input logic [WORD_W-1:0] word);
      texel_request_type item;
      logic [SLOT_W-1:0] slot;
      if (texel_scoreboard::reads_palette(cur_fmt, cur_width, cur_entries, col, row, word,
                                          slot) && !slot_written[slot]) begin
         send_palette(slot, $urandom());
      end
      item.command      = CMD_CONVERT;
      item.palette_slot = SLOT_W'($urandom());
      item.column       = col;
      item.row          = row;
      item.source_word  = word;
      push_request(item);
   endtask

   // Stop requests and wait until every response is in and the pipe is quiet.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      do begin
         while (scoreboard.pending() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
      end while (scoreboard.pending() != 0);
   endtask

   // Write all three registers; valid stays high across the writes.
   task automatic program_settings(input color_format_type f, input int w, input int n);
      for (int i = 0; i < 3; i++) begin
         csr_bus.valid <= 1'b1;
         case (i)
            0: begin
               csr_bus.index <= CSR_COLOR_FORMAT;
               csr_bus.data  <= CSR_DAT_W'(f);
            end
            1: begin
               csr_bus.index <= CSR_TEXTURE_WIDTH;
               csr_bus.data  <= CSR_DAT_W'(w);
            end
            default: begin
               csr_bus.index <= CSR_PALETTE_ENTRIES;
               csr_bus.data  <= CSR_DAT_W'(n);
            end
         endcase
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      cur_fmt     = f;
      cur_width   = WIDTH_W'(w);
      cur_entries = ENTRIES_W'(n);
   endtask

   // Random settings, leaning toward the extremes now and then.
   task automatic random_settings();
      color_format_type f;
      int               w;
      int               n;
      int               r;
      f = color_format_type'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 8) w = 0;
      else if (r < 18) w = MAX_DIM;
      else if (r < 23) w = (1 << WIDTH_W) - 1;
      else if (r < 30) w = $urandom_range(MAX_DIM + 1, (1 << WIDTH_W) - 1);
      else if (r < 50) w = $urandom_range(1, 16);
      else w = $urandom_range(1, MAX_DIM);
      r = $urandom_range(0, 99);
      if (f == FMT_INDEXED4 && r < 75) n = $urandom_range(1, 16);
      else if (r < 83) n = $urandom_range(1, PAL_DEPTH);
      else if (r < 88) n = 0;
      else if (r < 94) n = PAL_DEPTH;
      else n = $urandom_range(PAL_DEPTH + 1, (1 << ENTRIES_W) - 1);
      program_settings(f, w, n);
   endtask

   // One random item; indexed conversions mostly hit valid entries.
   task automatic random_item();
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [WORD_W-1:0]  word;
      logic [3:0]         nib;
      int                 limit;
      if ($urandom_range(0, 99) < 15) begin
         send_palette(SLOT_W'($urandom()), $urandom());
         return;
      end
      col   = COORD_W'($urandom());
      row   = COORD_W'($urandom());
      word  = $urandom();
      limit = (cur_entries > PAL_DEPTH) ? PAL_DEPTH : cur_entries;
      if (cur_fmt == FMT_INDEXED8 && limit > 0 && $urandom_range(0, 99) < 85) begin
         word[7:0] = 8'($urandom_range(0, limit - 1));
      end else if (cur_fmt == FMT_INDEXED4 && limit > 0 && $urandom_range(0, 99) < 85) begin
         nib = 4'($urandom_range(0, ((limit > 16) ? 16 : limit) - 1));
         if ((row[0] & cur_width[0]) ^ col[0]) begin
            word[7:4] = nib;
         end else begin
            word[3:0] = nib;
         end
      end
      send_convert(col, row, word);
   endtask

   // Stimulus.
   initial begin
      int issued;
      int phase_items;
      slot_written         = '0;
      burst_left           = 0;
      cur_fmt              = FMT_RGBA32;
      cur_width            = WIDTH_W'(1);
      cur_entries          = ENTRIES_W'(1);
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_PALETTE_WRITE;
      req_bus.palette_slot <= '0;
      req_bus.column       <= '0;
      req_bus.row          <= '0;
      req_bus.source_word  <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_COLOR_FORMAT;
      csr_bus.data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Direct RGBA32 at the corners of the largest texture.
      program_settings(FMT_RGBA32, MAX_DIM, 1);
      send_convert(0, 0, 32'h0000_0000);
      send_convert(1023, 1023, 32'hFFFF_FFFF);
      send_convert(37, 5, 32'h1234_5678);
      drain_pipeline();

      // RGBA4444 with a zero width; the upper halfword is ignored.
      program_settings(FMT_RGBA4444, 0, 1);
      send_convert(5, 7, 32'hABCD_1234);
      send_convert(1023, 1023, 32'h0000_FFFF);
      send_convert(0, 0, 32'hFFFF_0000);
      drain_pipeline();

      // 8-bit indexed with an oversized width and a full palette.
      program_settings(FMT_INDEXED8, (1 << WIDTH_W) - 1, PAL_DEPTH);
      send_palette(0, 32'h1122_3344);
      send_palette(255, 32'hFFFF_FFFF);
      send_palette(128, 32'h8000_0001);
      send_convert(1023, 1023, 32'hFFFF_FF00);
      send_convert(3, 9, 32'h0000_00FF);
      send_convert(2, 2, 32'h0000_0080);
      drain_pipeline();

      // No valid entries: every index is an error.
      program_settings(FMT_INDEXED8, 513, 0);
      send_convert(1, 1, 32'h0000_0000);
      drain_pipeline();

      // Entry count above the store depth is clamped to the depth.
      program_settings(FMT_INDEXED8, 100, (1 << ENTRIES_W) - 1);
      send_convert(10, 20, 32'h0000_00FF);
      send_convert(11, 21, 32'h0000_007F);
      drain_pipeline();

      // 4-bit indexed with an odd width: pixel parity picks the nibble.
      program_settings(FMT_INDEXED4, 3, 16);
      send_palette(1, 32'hA1B2_C3D4);
      send_palette(15, 32'h0F0F_F0F0);
      send_convert(0, 0, 32'h0000_00F1);
      send_convert(1, 0, 32'h0000_00F1);
      send_convert(0, 1, 32'h0000_001F);
      drain_pipeline();

      // 4-bit index past a small entry count.
      program_settings(FMT_INDEXED4, 4, 3);
      send_convert(0, 0, 32'h0000_000F);
      send_convert(3, 0, 32'h0000_002F);

      // Random phases, each under fresh settings.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         drain_pipeline();
         random_settings();
         phase_items = $urandom_range(60, 140);
         repeat (phase_items) begin
            random_item();
            issued++;
         end
      end
      drain_pipeline();

      if (scoreboard.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tfc_pkg.sv
hw/rtl/tfc_ifs.sv
hw/rtl/tfc_csr.sv
hw/rtl/tfc_front.sv
hw/rtl/tfc_back.sv
hw/rtl/texel_format_converter.sv
test/texel_format_converter_test.sv
